### hdl/mtp_pkg.sv
// shared types, constants and helper functions for the mt19937 generator
package mtp_pkg;

   localparam int STATE_WORDS  = 624;
   localparam int SHIFT_OFFSET = 397;
   localparam int KEY_WORDS    = 16;

   localparam int POS_W  = 10;
   localparam int KIDX_W = 4;
   localparam int KLEN_W = 5;

   localparam logic [POS_W-1:0] LAST_IDX   = POS_W'(STATE_WORDS - 1);
   localparam logic [POS_W-1:0] WORDS_CNT  = POS_W'(STATE_WORDS);
   localparam logic [POS_W-1:0] FAR_SPLIT  = POS_W'(STATE_WORDS - SHIFT_OFFSET);
   localparam logic [POS_W-1:0] FAR_ADD    = POS_W'(SHIFT_OFFSET);

   localparam logic [31:0] LIN_MULT   = 32'd1812433253;
   localparam logic [31:0] KEY_BASE   = 32'd19650218;
   localparam logic [31:0] KEY_MULT1  = 32'd1664525;
   localparam logic [31:0] KEY_MULT2  = 32'd1566083941;
   localparam logic [31:0] BOOT_SEED  = 32'd5489;
   localparam logic [31:0] HEAD_WORD  = 32'h8000_0000;
   localparam logic [31:0] TWIST_MAT  = 32'h9908_b0df;

   typedef enum logic [1:0] {
      ACT_SEED  = 2'd0,
      ACT_KEYWR = 2'd1,
      ACT_KEYSD = 2'd2,
      ACT_DRAW  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      MODE_BOOT,
      MODE_SCALAR,
      MODE_KEY
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LS_HEAD,
      ST_LS_MUL,
      ST_LS_WR,
      ST_KS_RD,
      ST_KS_WR,
      ST_KS_WRAP,
      ST_KS_HEAD,
      ST_RG_PRE,
      ST_RG_NXT,
      ST_RG_FAR,
      ST_RG_WR,
      ST_DR_RD,
      ST_DR_OUT
   } state_type;

   localparam logic CSR_SEED   = 1'b0;
   localparam logic CSR_KEYLEN = 1'b1;

   function automatic logic [31:0] twist(input logic [31:0] u, input logic [31:0] v);
      logic [31:0] y;
      y = {u[31], v[30:0]};
      return (y >> 1) ^ (v[0] ? TWIST_MAT : 32'd0);
   endfunction

   function automatic logic [31:0] temper(input logic [31:0] x);
      logic [31:0] y;
      y = x ^ (x >> 11);
      y = y ^ ((y << 7) & 32'h9d2c_5680);
      y = y ^ ((y << 15) & 32'hefc6_0000);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

### hdl/mtp_ram.sv
// generic single write port, single read port ram with registered read
module mtp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 624
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

### hdl/mersenne_twister_prng_core.sv
// top level of the mt19937 generator: sequencer, shared multiplier, state ram, csr port
//
// MT19937 32-bit generator. Each request word carries an action in tuser (0 reseed from
// the seed register, 1 store a key word, 2 reseed from the key store, 3 draw) and returns
// exactly one response word: the tempered output for a draw, zero otherwise. The 624-word
// state lives in a single-port-read ram, and one 32x32 multiplier is shared by both seeding
// recurrences, so work is done one state word at a time. After reset the block seeds itself
// with 5489 with req_tready low. When the read position has reached the end of the state, a
// draw first regenerates it, reading the next and the far word for each state word. A key
// reseed runs three passes over the state, a multiply step and a write step per word.
// A new request is taken once the response is gone.
module mersenne_twister_prng_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // key_index [3:0], key_word [35:4], zeros above
   input  logic [1:0]  req_tuser,   // action [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // random_word [31:0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mtp_pkg::*;

   state_type           state_ff, state_in;
   mode_type            mode_ff, mode_in;
   logic                pass2_ff, pass2_in;
   logic [POS_W-1:0]    i_ff, i_in;
   logic [POS_W-1:0]    k_ff, k_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [KIDX_W-1:0]   j_ff, j_in;
   logic [31:0]         prev_ff, prev_in;
   logic [31:0]         prod_ff, prod_in;
   logic [31:0]         cur_ff, cur_in;
   logic [31:0]         nxtw_ff, nxtw_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         rsp_data_ff, rsp_data_in;
   logic [31:0]         seed_ff;
   logic [KLEN_W-1:0]   keylen_ff;
   logic [31:0]         key_ff [KEY_WORDS];

   logic                ram_we;
   logic [POS_W-1:0]    ram_waddr, ram_raddr;
   logic [31:0]         ram_wdata, ram_rdata;

   logic [31:0]         mul_a, mul_b;
   logic [63:0]         mul_full;
   logic                req_accept, csr_write;
   action_type          req_action;
   logic [KIDX_W-1:0]   req_kidx;
   logic [31:0]         req_kword;
   logic [KLEN_W-1:0]   len_sat;
   logic [KLEN_W-1:0]   j_next;
   logic [POS_W-1:0]    nxt_idx, far_idx;
   logic [31:0]         ks_val, ls_val;

   mtp_ram #(.WIDTH(32), .DEPTH(STATE_WORDS)) u_state (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_action = action_type'(req_tuser);
   assign req_kidx   = req_tdata[3:0];
   assign req_kword  = req_tdata[35:4];
   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == CSR_KEYLEN) ? {27'd0, keylen_ff} : seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff   <= BOOT_SEED;
         keylen_ff <= KLEN_W'(1);
      end else if (csr_write) begin
         if (csr_paddr[2] == CSR_SEED) begin
            seed_ff <= csr_pwdata;
         end else begin
            keylen_ff <= csr_pwdata[KLEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_action == ACT_KEYWR) begin
         key_ff[req_kidx] <= req_kword;
      end
   end

   // shared multiplier, low word only
   assign mul_full = {32'd0, mul_a} * {32'd0, mul_b};

   assign len_sat = (keylen_ff == '0) ? KLEN_W'(1) :
                    (keylen_ff > KLEN_W'(KEY_WORDS)) ? KLEN_W'(KEY_WORDS) : keylen_ff;
   assign j_next  = {1'b0, j_ff} + KLEN_W'(1);
   assign nxt_idx = (i_ff == LAST_IDX) ? '0 : i_ff + POS_W'(1);
   assign far_idx = (i_ff < FAR_SPLIT) ? i_ff + FAR_ADD : i_ff - FAR_SPLIT;
   assign ls_val  = prod_ff + {22'd0, i_ff};
   assign ks_val  = pass2_ff ? ((ram_rdata ^ prod_ff) - {22'd0, i_ff})
                             : ((ram_rdata ^ prod_ff) + key_ff[j_ff] + {28'd0, j_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LS_HEAD;
         mode_ff      <= MODE_BOOT;
         pos_ff       <= WORDS_CNT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pass2_ff    <= pass2_in;
      i_ff        <= i_in;
      k_ff        <= k_in;
      j_ff        <= j_in;
      prev_ff     <= prev_in;
      prod_ff     <= prod_in;
      cur_ff      <= cur_in;
      nxtw_ff     <= nxtw_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      pass2_in     = pass2_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      pos_in       = pos_ff;
      prev_in      = prev_ff;
      prod_in      = prod_ff;
      cur_in       = cur_ff;
      nxtw_in      = nxtw_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = i_ff;
      ram_wdata    = ks_val;
      ram_raddr    = i_ff;
      mul_a        = prev_ff ^ (prev_ff >> 30);
      mul_b        = LIN_MULT;

      case (state_ff)
         ST_IDLE: begin
            if (rsp_valid_ff && rsp_tready) begin
               rsp_valid_in = 1'b0;
            end
            if (req_accept) begin
               case (req_action)
                  ACT_SEED: begin
                     mode_in  = MODE_SCALAR;
                     state_in = ST_LS_HEAD;
                  end
                  ACT_KEYWR: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                  end
                  ACT_KEYSD: begin
                     mode_in  = MODE_KEY;
                     state_in = ST_LS_HEAD;
                  end
                  default: begin
                     if (pos_ff >= WORDS_CNT) begin
                        i_in     = '0;
                        state_in = ST_RG_PRE;
                     end else begin
                        state_in = ST_DR_RD;
                     end
                  end
               endcase
            end
         end
         ST_LS_HEAD: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            case (mode_ff)
               MODE_SCALAR: ram_wdata = seed_ff;
               MODE_KEY:    ram_wdata = KEY_BASE;
               default:     ram_wdata = BOOT_SEED;
            endcase
            prev_in  = ram_wdata;
            i_in     = POS_W'(1);
            state_in = ST_LS_MUL;
         end
         ST_LS_MUL: begin
            prod_in  = mul_full[31:0];
            state_in = ST_LS_WR;
         end
         ST_LS_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ls_val;
            prev_in   = ls_val;
            if (i_ff == LAST_IDX) begin
               if (mode_ff == MODE_KEY) begin
                  // the first key step mixes in word 0
                  prev_in  = KEY_BASE;
                  i_in     = POS_W'(1);
                  j_in     = '0;
                  k_in     = WORDS_CNT;
                  pass2_in = 1'b0;
                  state_in = ST_KS_RD;
               end else begin
                  pos_in   = WORDS_CNT;
                  state_in = ST_IDLE;
                  if (mode_ff != MODE_BOOT) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                  end
               end
            end else begin
               i_in     = i_ff + POS_W'(1);
               state_in = ST_LS_MUL;
            end
         end
         ST_KS_RD: begin
            mul_b    = pass2_ff ? KEY_MULT2 : KEY_MULT1;
            prod_in  = mul_full[31:0];
            state_in = ST_KS_WR;
         end
         ST_KS_WR: begin
            ram_we  = 1'b1;
            prev_in = ks_val;
            k_in    = k_ff - POS_W'(1);
            if (!pass2_ff) begin
               j_in = (j_next >= len_sat) ? '0 : j_next[KIDX_W-1:0];
            end
            if (i_ff == LAST_IDX) begin
               state_in = ST_KS_WRAP;
            end else begin
               i_in = i_ff + POS_W'(1);
               if (k_ff == POS_W'(1)) begin
                  if (!pass2_ff) begin
                     pass2_in = 1'b1;
                     k_in     = LAST_IDX;
                     state_in = ST_KS_RD;
                  end else begin
                     state_in = ST_KS_HEAD;
                  end
               end else begin
                  state_in = ST_KS_RD;
               end
            end
         end
         ST_KS_WRAP: begin
            // word 0 follows the last word on wraparound
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = prev_ff;
            i_in      = POS_W'(1);
            if (k_ff == '0) begin
               if (!pass2_ff) begin
                  pass2_in = 1'b1;
                  k_in     = LAST_IDX;
                  state_in = ST_KS_RD;
               end else begin
                  state_in = ST_KS_HEAD;
               end
            end else begin
               state_in = ST_KS_RD;
            end
         end
         ST_KS_HEAD: begin
            ram_we       = 1'b1;
            ram_waddr    = '0;
            ram_wdata    = HEAD_WORD;
            pos_in       = WORDS_CNT;
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
            state_in     = ST_IDLE;
         end
         ST_RG_PRE: begin
            ram_raddr = '0;
            state_in  = ST_RG_NXT;
         end
         ST_RG_NXT: begin
            ram_raddr = nxt_idx;
            if (i_ff == '0) begin
               cur_in = ram_rdata;
            end
            state_in = ST_RG_FAR;
         end
         ST_RG_FAR: begin
            ram_raddr = far_idx;
            nxtw_in   = ram_rdata;
            state_in  = ST_RG_WR;
         end
         ST_RG_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata ^ twist(cur_ff, nxtw_ff);
            cur_in    = nxtw_ff;
            if (i_ff == LAST_IDX) begin
               pos_in   = '0;
               state_in = ST_DR_RD;
            end else begin
               i_in     = i_ff + POS_W'(1);
               state_in = ST_RG_NXT;
            end
         end
         ST_DR_RD: begin
            ram_raddr = pos_ff;
            state_in  = ST_DR_OUT;
         end
         ST_DR_OUT: begin
            rsp_data_in  = temper(ram_rdata);
            rsp_valid_in = 1'b1;
            pos_in       = pos_ff + POS_W'(1);
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

### test/mersenne_twister_prng_core_tb.sv
// self-checking testbench for the mt19937 generator core
module mersenne_twister_prng_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mtp_pkg::*;

   localparam int STALL_LIMIT = 40000;
   localparam int N_RANDOM    = 700;

   localparam logic [2:0] CSR_SEED_ADDR   = 3'd0;
   localparam logic [2:0] CSR_KEYLEN_ADDR = 3'd4;

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [39:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid, rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   mersenne_twister_prng_core dut (.*);

   // predictor copy of the generator
   logic [31:0] mt_words [STATE_WORDS];
   int unsigned mt_pos;
   logic [31:0] key_mem [KEY_WORDS];
   logic [31:0] seed_reg;
   logic [4:0]  keylen_reg;

   logic [31:0] expected_words [$];
   int          mismatches;
   int          idle_cycles;
   bit          busy_idle;   // when set, no random idling on either side

   typedef struct {
      action_type  act;
      logic [3:0]  idx;
      logic [31:0] data;
      bit          known;
      logic [31:0] word;
   } stim_row_type;

   function automatic logic [31:0] mix(input logic [31:0] p, input logic [31:0] m);
      logic [63:0] prod;
      prod = 64'(p ^ (p >> 30)) * 64'(m);
      return prod[31:0];
   endfunction

   function automatic void seed_linear(input logic [31:0] s);
      mt_words[0] = s;
      for (int i = 1; i < STATE_WORDS; i++)
         mt_words[i] = mix(mt_words[i-1], LIN_MULT) + 32'(i);
      mt_pos = STATE_WORDS;
   endfunction

   function automatic void seed_from_key();
      int len, i, j, k;
      len = keylen_reg;
      if (len < 1) len = 1;
      if (len > KEY_WORDS) len = KEY_WORDS;
      seed_linear(KEY_BASE);
      i = 1; j = 0;
      for (k = (STATE_WORDS > len) ? STATE_WORDS : len; k > 0; k--) begin
         mt_words[i] = (mt_words[i] ^ mix(mt_words[i-1], KEY_MULT1)) + key_mem[j] + 32'(j);
         j++;
         if (j >= len) j = 0;
         i++;
         if (i >= STATE_WORDS) begin
            mt_words[0] = mt_words[STATE_WORDS-1];
            i = 1;
         end
      end
      for (k = STATE_WORDS - 1; k > 0; k--) begin
         mt_words[i] = (mt_words[i] ^ mix(mt_words[i-1], KEY_MULT2)) - 32'(i);
         i++;
         if (i >= STATE_WORDS) begin
            mt_words[0] = mt_words[STATE_WORDS-1];
            i = 1;
         end
      end
      mt_words[0] = HEAD_WORD;
      mt_pos = STATE_WORDS;
   endfunction

   function automatic logic [31:0] shuffle_mix(input logic [31:0] u, input logic [31:0] v);
      logic [31:0] y;
      y = {u[31], v[30:0]};
      return (y >> 1) ^ (v[0] ? 32'h9908_b0df : 32'd0);
   endfunction

   function automatic logic [31:0] draw_next();
      logic [31:0] y;
      if (mt_pos >= STATE_WORDS) begin
         for (int i = 0; i < STATE_WORDS; i++)
            mt_words[i] = mt_words[(i + SHIFT_OFFSET) % STATE_WORDS]
                        ^ shuffle_mix(mt_words[i], mt_words[(i + 1) % STATE_WORDS]);
         mt_pos = 0;
      end
      y = mt_words[mt_pos];
      mt_pos++;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & 32'h9d2c_5680);
      y = y ^ ((y << 15) & 32'hefc6_0000);
      y = y ^ (y >> 18);
      return y;
   endfunction

   function automatic logic [31:0] predict_word(input action_type a, input logic [3:0] idx,
                                                input logic [31:0] d);
      case (a)
         ACT_SEED:  seed_linear(seed_reg);
         ACT_KEYWR: key_mem[idx] = d;
         ACT_KEYSD: seed_from_key();
         default:   return draw_next();
      endcase
      return 32'd0;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver with random stalls
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= busy_idle ? 1'b1 : ($urandom_range(99) >= 36);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", rsp_tdata);
         end else begin
            logic [31:0] w;
            w = expected_words.pop_front();
            if (w !== rsp_tdata) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("word mismatch: expected %h got %h", w, rsp_tdata);
            end
         end
      end
   end

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= addr; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (addr == CSR_SEED_ADDR) seed_reg = val;
      else if (addr == CSR_KEYLEN_ADDR) keylen_reg = val[4:0];
   endtask

   task automatic wait_drained();
      while (expected_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // word is predicted once it is accepted
   task automatic send_word(input action_type a, input logic [3:0] idx, input logic [31:0] d,
                            input bit known, input logic [31:0] kw);
      logic [31:0] p;
      if (!busy_idle)
         while ($urandom_range(99) < 36) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= a;
      req_tdata  <= {4'd0, d, idx};
      do @(posedge clock); while (!req_tready);
      req_tvalid <= 1'b0;
      p = predict_word(a, idx, d);
      if (known && p !== kw) begin
         mismatches++;
         if (mismatches <= 10) $display("table row disagrees: %h vs %h", kw, p);
      end
      expected_words.push_back(p);
      @(posedge clock);
   endtask

   // random key writes into the first slots, then a key reseed over written slots only
   task automatic random_key_run(output int sent);
      int len;
      len = $urandom_range(1, 16);
      csr_write(CSR_KEYLEN_ADDR, (len == 16 && $urandom_range(1)) ? 32'd31 : 32'(len));
      for (int i = 0; i < len; i++)
         send_word(ACT_KEYWR, 4'(i), $urandom, 1'b0, 32'd0);
      send_word(ACT_KEYSD, 4'($urandom), $urandom, 1'b1, 32'd0);
      sent = len + 1;
   endtask

   stim_row_type table_rows [$];

   initial begin
      int n;
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = '0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      rsp_tready = 1'b0;
      mismatches = 0; idle_cycles = 0; busy_idle = 1'b0;
      seed_reg = BOOT_SEED; keylen_reg = 5'd1;
      for (int i = 0; i < KEY_WORDS; i++)
         key_mem[i] = '0;
      seed_linear(BOOT_SEED);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // first words after boot seed 5489 are well known
      table_rows.push_back('{ACT_DRAW,  4'h0, 32'h0, 1'b1, 32'd3499211612});
      table_rows.push_back('{ACT_DRAW,  4'hf, 32'hffffffff, 1'b1, 32'd581869302});
      table_rows.push_back('{ACT_KEYWR, 4'h0, 32'h00000123, 1'b1, 32'd0});
      table_rows.push_back('{ACT_KEYWR, 4'h1, 32'h00000234, 1'b1, 32'd0});
      table_rows.push_back('{ACT_KEYWR, 4'h2, 32'h00000345, 1'b1, 32'd0});
      table_rows.push_back('{ACT_KEYWR, 4'h3, 32'h00000456, 1'b1, 32'd0});
      table_rows.push_back('{ACT_KEYWR, 4'hf, 32'hffffffff, 1'b1, 32'd0});
      table_rows.push_back('{ACT_KEYWR, 4'he, 32'h00000000, 1'b1, 32'd0});
      table_rows.push_back('{ACT_KEYSD, 4'h0, 32'h0, 1'b1, 32'd0});
      table_rows.push_back('{ACT_DRAW,  4'h0, 32'h0, 1'b0, 32'd0});
      table_rows.push_back('{ACT_SEED,  4'h5, 32'h12345678, 1'b1, 32'd0});
      table_rows.push_back('{ACT_DRAW,  4'h0, 32'h0, 1'b1, 32'd3499211612});
      foreach (table_rows[r])
         send_word(table_rows[r].act, table_rows[r].idx, table_rows[r].data,
                   table_rows[r].known, table_rows[r].word);
      wait_drained();

      // the classic init_by_array key of four words gives a known first draw
      csr_write(CSR_KEYLEN_ADDR, 32'd4);
      send_word(ACT_KEYSD, 4'h0, 32'h0, 1'b1, 32'd0);
      send_word(ACT_DRAW, 4'h0, 32'h0, 1'b1, 32'd1067595299);
      wait_drained();
      // key length zero saturates to one, all slots written by now
      for (int i = 4; i < 14; i++) send_word(ACT_KEYWR, 4'(i), $urandom, 1'b0, 32'd0);
      csr_write(CSR_KEYLEN_ADDR, 32'd0);
      send_word(ACT_KEYSD, 4'h0, 32'h0, 1'b0, 32'd0);
      send_word(ACT_DRAW, 4'h0, 32'h0, 1'b0, 32'd0);
      wait_drained();
      csr_write(CSR_KEYLEN_ADDR, 32'd16);
      send_word(ACT_KEYSD, 4'h0, 32'h0, 1'b0, 32'd0);
      wait_drained();
      csr_write(CSR_SEED_ADDR, 32'hffffffff);
      send_word(ACT_SEED, 4'h0, 32'h0, 1'b0, 32'd0);
      send_word(ACT_DRAW, 4'h0, 32'h0, 1'b0, 32'd0);
      wait_drained();
      csr_write(CSR_SEED_ADDR, 32'd0);
      send_word(ACT_SEED, 4'h0, 32'h0, 1'b0, 32'd0);
      send_word(ACT_DRAW, 4'h0, 32'h0, 1'b0, 32'd0);
      wait_drained();

      // random part: mostly draws so the position crosses the regeneration point
      n = 0;
      while (n < N_RANDOM) begin
         int pick;
         int sent;
         pick = $urandom_range(99);
         busy_idle = (n >= 300 && n < 400);
         if (pick < 80) begin
            send_word(ACT_DRAW, 4'($urandom), $urandom, 1'b0, 32'd0); n++;
         end else if (pick < 92) begin
            send_word(ACT_KEYWR, 4'($urandom), $urandom, 1'b0, 32'd0); n++;
         end else if (pick < 96) begin
            wait_drained();
            csr_write(CSR_SEED_ADDR, $urandom);
            send_word(ACT_SEED, 4'($urandom), $urandom, 1'b0, 32'd0); n++;
         end else if (pick < 98) begin
            send_word(ACT_KEYSD, 4'($urandom), $urandom, 1'b0, 32'd0); n++;
         end else begin
            wait_drained();
            random_key_run(sent);
            n += sent;
         end
      end
      busy_idle = 1'b0;
      wait_drained();
      if (mismatches == 0 && expected_words.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
